// ===== rtl/cbm_pkg.sv =====
package cbm_pkg;

  localparam int unsigned RamBanks    = 4;
  localparam int unsigned MaxRomBanks = 512;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 4;

  typedef enum logic [2:0] {
    MapNone = 3'd0,
    MapMbc1 = 3'd1,
    MapMbc2 = 3'd2,
    MapMbc3 = 3'd3,
    MapMbc5 = 3'd4
  } map_kind_e;

  typedef enum logic [1:0] {
    TgtNone = 2'd0,
    TgtRom  = 2'd1,
    TgtRam  = 2'd2
  } target_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgMapperKind   = 2'd0,
    CfgRomBankCount = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [8:0] rom_bank;
    logic [3:0] ram_bank;
    logic       ram_on;
    logic       mode;
  } bank_state_t;

  typedef struct packed {
    target_e     target;
    logic [22:0] rom_address;
    logic [14:0] ram_address;
    logic        ram_write;
  } result_t;

endpackage

// ===== rtl/cartridge_bank_mapper.sv =====
// Cartridge bank mapper for a handheld console bus with MBC1, MBC2, MBC3
// and MBC5 style controllers.
// The input channel carries one bus access per beat (command, address and
// write data) under in_valid_i and in_stall_o. The output channel carries
// one result per beat (target, ROM address, RAM address and RAM write
// strobe) under out_valid_o and out_stall_i. Every access gives exactly
// one result, register writes included.
// The configuration channel writes the controller kind (index 0) and the
// log2 of the ROM bank count (index 1); it is always ready and should only
// be used while no access is in flight.
// An access goes through an input register and a result register, and a
// new access can be accepted in every cycle while the receiver does not
// stall. Bank registers are updated as an access leaves the input register,
// so the next access already sees the new banks.
// When the receiver stalls, the result register holds its beat, the input
// register keeps one more access, and then in_stall_o is raised.
// Reset selects no controller, two ROM banks, ROM bank 1, RAM bank 0, RAM
// disabled and ROM banking mode, and empties both registers.
module cartridge_bank_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbm_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [cbm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [15:0]                   address_i,
  input  logic [7:0]                    write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    target_o,
  output logic [22:0]                   rom_address_o,
  output logic [14:0]                   ram_address_o,
  output logic                          ram_write_o
);

  logic [2:0]           mapper_kind_q;
  logic [3:0]           rom_log2_q;
  cbm_pkg::bank_state_t state_q, state_d;
  cbm_pkg::result_t     result_d, result_q;

  logic        in_valid_q;
  logic        command_q;
  logic [15:0] address_q;
  logic [7:0]  write_data_q;
  logic        out_valid_q;
  logic        out_load;
  logic        in_move;
  logic        in_take;

  assign cfg_ready_o = 1'b1;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign in_move     = in_valid_q && out_load;
  assign in_stall_o  = in_valid_q && !out_load;
  assign in_take     = in_valid_i && !in_stall_o;

  cbm_xlate u_xlate (
    .mapper_kind_i        (mapper_kind_q),
    .rom_bank_count_log2_i(rom_log2_q),
    .state_i              (state_q),
    .command_i            (command_q),
    .address_i            (address_q),
    .write_data_i         (write_data_q),
    .state_o              (state_d),
    .result_o             (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapper_kind_q <= cbm_pkg::MapNone;
      rom_log2_q    <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cbm_pkg::CfgMapperKind:   mapper_kind_q <= cfg_data_i[2:0];
        cbm_pkg::CfgRomBankCount: rom_log2_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{rom_bank: 9'd1, ram_bank: 4'd0, ram_on: 1'b0, mode: 1'b0};
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_move) begin
        state_q <= state_d;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (in_move) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      command_q    <= command_i;
      address_q    <= address_i;
      write_data_q <= write_data_i;
    end
    if (in_move) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = result_q.target;
  assign rom_address_o = result_q.rom_address;
  assign ram_address_o = result_q.ram_address;
  assign ram_write_o   = result_q.ram_write;

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == cbm_pkg::TgtNone) |->
      (rom_address_o == 23'd0) && (ram_address_o == 15'd0) && !ram_write_o)
    else $error("idle target carries an address");

  a_write_is_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ram_write_o |-> (target_o == cbm_pkg::TgtRam))
    else $error("RAM write strobe outside RAM target");

  a_rom_no_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == cbm_pkg::TgtRom) |-> (ram_address_o == 15'd0))
    else $error("ROM result carries a RAM address");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!in_valid_q || in_move))
    else $error("input register overwritten");

  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_move) |-> $stable(state_q))
    else $error("bank state changed without an access");

endmodule

// ===== rtl/cbm_xlate.sv =====
module cbm_xlate (
  input  logic [2:0]          mapper_kind_i,
  input  logic [3:0]          rom_bank_count_log2_i,
  input  cbm_pkg::bank_state_t state_i,
  input  logic                command_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          write_data_i,
  output cbm_pkg::bank_state_t state_o,
  output cbm_pkg::result_t    result_o
);

  logic [3:0] wrap_tbl [16];

  for (genvar v = 0; v < 16; v++) begin : g_wrap
    localparam logic [3:0] WrapV = 4'(v % cbm_pkg::RamBanks);
    assign wrap_tbl[v] = WrapV;
  end

  logic [3:0] lg_sat;
  logic [9:0] bank_cnt;
  logic [8:0] rom_mask;
  logic [8:0] rom_bank_eff;
  logic [3:0] ram_bank_eff;
  logic [1:0] region;
  logic       enable_val;
  logic [4:0] lo5;
  logic [3:0] lo4;
  logic [6:0] lo7;

  always_comb begin
    lg_sat   = (rom_bank_count_log2_i > 4'd9) ? 4'd9 : rom_bank_count_log2_i;
    bank_cnt = 10'd1 << lg_sat;
    if (bank_cnt > 10'(cbm_pkg::MaxRomBanks)) begin
      bank_cnt = 10'(cbm_pkg::MaxRomBanks);
    end
    rom_mask     = 9'(bank_cnt - 10'd1);
    rom_bank_eff = state_i.rom_bank & rom_mask;
    ram_bank_eff = wrap_tbl[state_i.ram_bank];
    region       = address_i[14:13];
    enable_val   = (write_data_i[3:0] == 4'ha);
    lo5 = (write_data_i[4:0] == 5'd0) ? 5'd1 : write_data_i[4:0];
    lo4 = (write_data_i[3:0] == 4'd0) ? 4'd1 : write_data_i[3:0];
    lo7 = (write_data_i[6:0] == 7'd0) ? 7'd1 : write_data_i[6:0];
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{target: cbm_pkg::TgtNone, rom_address: '0, ram_address: '0,
                 ram_write: 1'b0};
    if (!address_i[15]) begin
      if (command_i) begin
        case (mapper_kind_i)
          cbm_pkg::MapMbc1: begin
            case (region)
              2'd0: state_o.ram_on = enable_val;
              2'd1: state_o.rom_bank = {1'b0, state_i.rom_bank[7:5], lo5};
              2'd2: begin
                if (!state_i.mode) begin
                  state_o.rom_bank = {2'b00, write_data_i[1:0], state_i.rom_bank[4:0]};
                end else begin
                  state_o.ram_bank = {2'b00, write_data_i[1:0]};
                end
              end
              default: begin
                state_o.mode = write_data_i[0];
                if (!write_data_i[0]) begin
                  state_o.ram_bank = 4'd0;
                end else begin
                  state_o.rom_bank = {4'd0, state_i.rom_bank[4:0]};
                end
              end
            endcase
          end
          cbm_pkg::MapMbc2: begin
            if (!address_i[14]) begin
              if (!address_i[8]) begin
                state_o.ram_on = enable_val;
              end else begin
                state_o.rom_bank = {5'd0, lo4};
              end
            end
          end
          cbm_pkg::MapMbc3: begin
            case (region)
              2'd0: state_o.ram_on = enable_val;
              2'd1: state_o.rom_bank = {2'b00, lo7};
              2'd2: begin
                if (write_data_i < 8'd8) begin
                  state_o.ram_bank = write_data_i[3:0];
                end
              end
              default: ;
            endcase
          end
          cbm_pkg::MapMbc5: begin
            case (region)
              2'd0: state_o.ram_on = enable_val;
              2'd1: begin
                if (!address_i[12]) begin
                  state_o.rom_bank = {state_i.rom_bank[8], write_data_i};
                end else begin
                  state_o.rom_bank = {write_data_i[0], state_i.rom_bank[7:0]};
                end
              end
              2'd2: state_o.ram_bank = write_data_i[3:0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end else begin
        result_o.target = cbm_pkg::TgtRom;
        if (!address_i[14]) begin
          result_o.rom_address = {9'd0, address_i[13:0]};
        end else begin
          result_o.rom_address = {rom_bank_eff, address_i[13:0]};
        end
      end
    end else if (address_i[15:13] == 3'b101) begin
      result_o.target      = cbm_pkg::TgtRam;
      result_o.ram_address = {ram_bank_eff[1:0], address_i[12:0]};
      result_o.ram_write   = command_i & state_i.ram_on;
    end
  end

endmodule
